// ----- hw/rtl/rrjs_pkg.sv -----
// ----------------------------------------------------------------------------
// rrjs_pkg
// Types, codes and helpers shared by the round-robin job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrjs_pkg;

  // result kinds
  typedef enum logic [1:0] {
    KIND_RELEASE = 2'd0,
    KIND_RAN     = 2'd1,
    KIND_IDLE    = 2'd2,
    KIND_LOAD    = 2'd3
  } kind_e;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // register indexes
  localparam int unsigned REG_SLOT_LENGTH = 0;

  localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

  // job waiting for its arrival time
  typedef struct packed {
    logic        valid;
    logic [4:0]  id;
    logic [15:0] arr;
    logic [15:0] rem;
  } pend_ent_t;

  // job in the ready queue
  typedef struct packed {
    logic        valid;
    logic [4:0]  id;
    logic [15:0] arr;
    logic [15:0] rem;
    logic        started;
    logic [31:0] slice_end;
  } rdy_ent_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } pend_ctl_t;

  typedef struct packed {
    logic pop;
    logic push;
  } rdy_ctl_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? U32_MAX : s[31:0];
  endfunction

endpackage

// ----- hw/rtl/rrjs_if.sv -----
// ----------------------------------------------------------------------------
// rrjs_if
// Input and result channels of the round-robin job scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rrjs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] job_arrival;
  logic [15:0] job_exec_time;

  modport source (output valid, func, job_arrival, job_exec_time, input ready);
  modport sink   (input valid, func, job_arrival, job_exec_time, output ready);
endinterface

interface rrjs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] event_time;
  logic [4:0]  job_id;
  logic [15:0] run_length;
  logic [15:0] remaining;
  logic        job_done;
  logic [31:0] wait_total;
  logic [31:0] busy_total;
  logic        all_finished;
  logic        last;

  modport source (output valid, kind, event_time, job_id, run_length, remaining, job_done,
                  wait_total, busy_total, all_finished, last, input ready);
  modport sink   (input valid, kind, event_time, job_id, run_length, remaining, job_done,
                  wait_total, busy_total, all_finished, last, output ready);
endinterface

// ----- hw/rtl/rrjs_pend_cell.sv -----
// ----------------------------------------------------------------------------
// rrjs_pend_cell
// One slot of the arrival-sorted pending chain: sorted insert and pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrjs_pend_cell
  import rrjs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pend_ctl_t ctl_i,
  input  pend_ent_t new_i,
  input  pend_ent_t left_ent_i,
  input  logic      left_beyond_i,
  input  pend_ent_t right_ent_i,
  output pend_ent_t ent_o,
  output logic      beyond_o
);

  pend_ent_t ent_d, ent_q;

  // this slot lies at or past the insert point
  assign beyond_o = !ent_q.valid || (ent_q.arr > new_i.arr);

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.insert) begin
      if (left_beyond_i) begin
        ent_d = left_ent_i;
      end else if (beyond_o) begin
        ent_d = new_i;
      end
    end else if (ctl_i.pop) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- hw/rtl/rrjs_ready_cell.sv -----
// ----------------------------------------------------------------------------
// rrjs_ready_cell
// One slot of the ready queue chain: shifts toward the head on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrjs_ready_cell
  import rrjs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rdy_ctl_t ctl_i,
  input  logic     push_here_i,
  input  rdy_ent_t push_ent_i,
  input  rdy_ent_t right_ent_i,
  output rdy_ent_t ent_o
);

  rdy_ent_t ent_d, ent_q;

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.push && push_here_i) begin
      ent_d = push_ent_i;
    end else if (ctl_i.pop) begin
      ent_d = right_ent_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o = ent_q;

endmodule

// ----- hw/rtl/round_robin_job_scheduler.sv -----
// ----------------------------------------------------------------------------
// round_robin_job_scheduler
// Round-robin job scheduler built from a sorted pending chain and a ready chain.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        contents
//  in_ch     in   valid / ready    func, job_arrival, job_exec_time
//  out_ch    out  valid / ready    kind, times, job id, slice data, totals, last
//  apb       in   psel / penable   slot_length at byte address 0
//
//  a load inserts in place in the pending chain as it is taken.
//  a step is taken in idle, then gives one release result per arrived job,
//  popped from the pending chain, and then the run or idle result.
//  a new item is taken only after the previous item's last result is
//  registered; a stalled result holds the sequencer.
//  reset empties both chains and clears time and totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module round_robin_job_scheduler
  import rrjs_pkg::*;
#(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  rrjs_in_if.sink            in_ch,
  rrjs_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_JOBS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_STEP = 1'b1;

  logic          state_q, state_d;
  logic [15:0]   slot_q;
  logic [CW-1:0] pc_q, pc_d, rc_q, rc_d, loaded_q, loaded_d;
  logic [31:0]   time_q, time_d, wait_q, wait_d, busy_q, busy_d;

  // result register
  logic          ov_q, ov_d;
  logic [1:0]    o_kind_q, o_kind_d;
  logic [31:0]   o_time_q, o_time_d, o_wait_q, o_wait_d, o_busy_q, o_busy_d;
  logic [4:0]    o_id_q, o_id_d;
  logic [15:0]   o_run_q, o_run_d, o_rem_q, o_rem_d;
  logic          o_done_q, o_done_d, o_fin_q, o_fin_d, o_last_q, o_last_d;

  pend_ent_t     pend_ent [MAX_JOBS];
  logic          pend_bey [MAX_JOBS];
  rdy_ent_t      rdy_ent  [MAX_JOBS];
  pend_ctl_t     pend_ctl;
  rdy_ctl_t      rdy_ctl;
  pend_ent_t     pend_new;
  rdy_ent_t      rdy_new;
  logic [CW-1:0] tail;

  logic          can_emit, in_acc;

  // apb register
  assign pready = 1'b1;
  assign prdata = {16'h0000, slot_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 16'd1;
    end else if (psel && penable && pwrite && paddr == 3'(REG_SLOT_LENGTH * 4)) begin
      slot_q <= pwdata[15:0];
    end
  end

  // pending chain
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_pend
    pend_ent_t l_ent, r_ent;
    logic      l_bey;
    if (i == 0) begin : g_first
      assign l_ent = '0;
      assign l_bey = 1'b0;
    end else begin : g_mid
      assign l_ent = pend_ent[i-1];
      assign l_bey = pend_bey[i-1];
    end
    if (i == MAX_JOBS - 1) begin : g_last
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = pend_ent[i+1];
    end
    rrjs_pend_cell u_cell (
      .clk_i, .rst_ni,
      .ctl_i(pend_ctl), .new_i(pend_new),
      .left_ent_i(l_ent), .left_beyond_i(l_bey), .right_ent_i(r_ent),
      .ent_o(pend_ent[i]), .beyond_o(pend_bey[i])
    );
  end

  // ready chain
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_rdy
    rdy_ent_t r_ent;
    if (i == MAX_JOBS - 1) begin : g_last
      assign r_ent = '0;
    end else begin : g_inner
      assign r_ent = rdy_ent[i+1];
    end
    rrjs_ready_cell u_cell (
      .clk_i, .rst_ni,
      .ctl_i(rdy_ctl), .push_here_i(tail == CW'(i)), .push_ent_i(rdy_new),
      .right_ent_i(r_ent), .ent_o(rdy_ent[i])
    );
  end

  assign can_emit    = !ov_q || out_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && can_emit;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // slice arithmetic on the ready head
  logic [15:0] slot_eff, run16, rem_new;
  logic [31:0] wait_delta;
  logic        rel_go, run_done, load_bad;

  assign slot_eff   = (slot_q == 16'd0) ? 16'd1 : slot_q;
  assign run16      = (rdy_ent[0].rem < slot_eff) ? rdy_ent[0].rem : slot_eff;
  assign rem_new    = rdy_ent[0].rem - run16;
  assign run_done   = (rem_new == 16'd0);
  assign wait_delta = rdy_ent[0].started ? (time_q - rdy_ent[0].slice_end)
                                         : (time_q - {16'h0000, rdy_ent[0].arr});
  assign rel_go     = (pc_q != '0) && ({16'h0000, pend_ent[0].arr} <= time_q);
  assign load_bad   = (in_ch.job_exec_time == 16'd0) || (loaded_q >= MAX_CNT)
                      || (pc_q >= MAX_CNT);

  // sequencer
  always_comb begin
    state_d  = state_q;
    pc_d     = pc_q;
    rc_d     = rc_q;
    loaded_d = loaded_q;
    time_d   = time_q;
    wait_d   = wait_q;
    busy_d   = busy_q;
    pend_ctl = '0;
    rdy_ctl  = '0;
    tail     = rc_q;
    pend_new.valid = 1'b1;
    pend_new.id    = 5'(loaded_q + CW'(1));
    pend_new.arr   = in_ch.job_arrival;
    pend_new.rem   = in_ch.job_exec_time;
    rdy_new.valid     = 1'b1;
    rdy_new.id        = pend_ent[0].id;
    rdy_new.arr       = pend_ent[0].arr;
    rdy_new.rem       = pend_ent[0].rem;
    rdy_new.started   = 1'b0;
    rdy_new.slice_end = 32'd0;

    ov_d     = ov_q && !out_ch.ready;
    o_kind_d = o_kind_q;
    o_time_d = o_time_q;
    o_id_d   = o_id_q;
    o_run_d  = o_run_q;
    o_rem_d  = o_rem_q;
    o_done_d = o_done_q;
    o_wait_d = o_wait_q;
    o_busy_d = o_busy_q;
    o_fin_d  = o_fin_q;
    o_last_d = o_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_STEP) begin
            state_d = S_STEP;
          end else begin
            ov_d     = 1'b1;
            o_kind_d = KIND_LOAD;
            o_time_d = time_q;
            o_run_d  = 16'd0;
            o_done_d = 1'b0;
            o_wait_d = wait_q;
            o_busy_d = busy_q;
            o_last_d = 1'b1;
            if (load_bad) begin
              o_id_d  = 5'd0;
              o_rem_d = 16'd0;
              o_fin_d = (pc_q == '0) && (rc_q == '0);
            end else begin
              pend_ctl.insert = 1'b1;
              loaded_d = loaded_q + CW'(1);
              pc_d     = pc_q + CW'(1);
              o_id_d   = pend_new.id;
              o_rem_d  = in_ch.job_exec_time;
              o_fin_d  = 1'b0;
            end
          end
        end
      end
      S_STEP: begin
        if (can_emit) begin
          ov_d     = 1'b1;
          o_time_d = time_q;
          if (rel_go) begin
            // release the head of the pending chain
            pend_ctl.pop = 1'b1;
            rdy_ctl.push = 1'b1;
            pc_d     = pc_q - CW'(1);
            rc_d     = rc_q + CW'(1);
            o_kind_d = KIND_RELEASE;
            o_id_d   = pend_ent[0].id;
            o_run_d  = 16'd0;
            o_rem_d  = pend_ent[0].rem;
            o_done_d = 1'b0;
            o_wait_d = wait_q;
            o_busy_d = busy_q;
            o_fin_d  = 1'b0;
            o_last_d = 1'b0;
          end else if (rc_q != '0) begin
            // run the ready head for one slice
            state_d  = S_IDLE;
            time_d   = sat_add32(time_q, {16'h0000, run16});
            wait_d   = sat_add32(wait_q, wait_delta);
            busy_d   = sat_add32(busy_q, {16'h0000, run16});
            rdy_ctl.pop  = 1'b1;
            rdy_ctl.push = !run_done;
            tail         = rc_q - CW'(1);
            rdy_new      = rdy_ent[0];
            rdy_new.rem       = rem_new;
            rdy_new.started   = 1'b1;
            rdy_new.slice_end = time_d;
            rc_d     = run_done ? rc_q - CW'(1) : rc_q;
            o_kind_d = KIND_RAN;
            o_id_d   = rdy_ent[0].id;
            o_run_d  = run16;
            o_rem_d  = rem_new;
            o_done_d = run_done;
            o_wait_d = wait_d;
            o_busy_d = busy_d;
            o_fin_d  = (pc_q == '0) && (rc_d == '0);
            o_last_d = 1'b1;
          end else begin
            // idle tick
            state_d  = S_IDLE;
            time_d   = sat_add32(time_q, 32'd1);
            o_kind_d = KIND_IDLE;
            o_id_d   = 5'd0;
            o_run_d  = 16'd1;
            o_rem_d  = 16'd0;
            o_done_d = 1'b0;
            o_wait_d = wait_q;
            o_busy_d = busy_q;
            o_fin_d  = (pc_q == '0);
            o_last_d = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= '0;
      rc_q     <= '0;
      loaded_q <= '0;
      time_q   <= 32'd0;
      wait_q   <= 32'd0;
      busy_q   <= 32'd0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      pc_q     <= pc_d;
      rc_q     <= rc_d;
      loaded_q <= loaded_d;
      time_q   <= time_d;
      wait_q   <= wait_d;
      busy_q   <= busy_d;
      ov_q     <= ov_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    o_kind_q <= o_kind_d;
    o_time_q <= o_time_d;
    o_id_q   <= o_id_d;
    o_run_q  <= o_run_d;
    o_rem_q  <= o_rem_d;
    o_done_q <= o_done_d;
    o_wait_q <= o_wait_d;
    o_busy_q <= o_busy_d;
    o_fin_q  <= o_fin_d;
    o_last_q <= o_last_d;
  end

  assign out_ch.valid        = ov_q;
  assign out_ch.kind         = o_kind_q;
  assign out_ch.event_time   = o_time_q;
  assign out_ch.job_id       = o_id_q;
  assign out_ch.run_length   = o_run_q;
  assign out_ch.remaining    = o_rem_q;
  assign out_ch.job_done     = o_done_q;
  assign out_ch.wait_total   = o_wait_q;
  assign out_ch.busy_total   = o_busy_q;
  assign out_ch.all_finished = o_fin_q;
  assign out_ch.last         = o_last_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives loads and scheduling steps into the round-robin job scheduler and
// checks every result beat against a built-in predictor of the scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected result beat
typedef struct {
  logic [1:0]  kind;
  logic [31:0] event_time;
  logic [4:0]  job_id;
  logic [15:0] run_length;
  logic [15:0] remaining;
  logic        job_done;
  logic [31:0] wait_total;
  logic [31:0] busy_total;
  logic        all_finished;
  logic        last;
} sched_beat_t;

class sched_scoreboard;
  localparam int NJOBS = 16;
  logic [15:0] slot_len;
  logic [15:0] arr_tab [NJOBS];
  logic [15:0] rem_tab [NJOBS];
  bit          started_tab [NJOBS];
  logic [31:0] slice_end_tab [NJOBS];
  int          pend_q [$];
  int          ready_q [$];
  logic [31:0] now;
  logic [31:0] wait_acc;
  logic [31:0] busy_acc;
  int          loaded;
  sched_beat_t pending_beats [$];
  int          errors;
  int          beats_seen;

  function new();
    slot_len = 16'd1;
    now = '0;
    wait_acc = '0;
    busy_acc = '0;
    loaded = 0;
    errors = 0;
    beats_seen = 0;
    foreach (started_tab[i]) begin
      started_tab[i] = 0;
      slice_end_tab[i] = '0;
    end
  endfunction

  function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function void add_beat(logic [1:0] k, logic [31:0] t, logic [4:0] id,
                         logic [15:0] run, logic [15:0] rem, logic done);
    sched_beat_t b;
    b.kind = k;
    b.event_time = t;
    b.job_id = id;
    b.run_length = run;
    b.remaining = rem;
    b.job_done = done;
    b.wait_total = wait_acc;
    b.busy_total = busy_acc;
    b.all_finished = (pend_q.size() == 0) && (ready_q.size() == 0);
    b.last = 1'b0;
    pending_beats.push_back(b);
  endfunction

  // note an accepted input beat and queue its expected results
  function void note_input(logic fn, logic [15:0] arr, logic [15:0] ex);
    int pos;
    int j;
    logic [15:0] slot;
    logic [15:0] run;
    logic [31:0] t0;
    if (fn == rrjs_pkg::FUNC_LOAD) begin
      if (ex == 0 || loaded >= NJOBS || pend_q.size() >= NJOBS) begin
        add_beat(rrjs_pkg::KIND_LOAD, now, 5'd0, 16'd0, 16'd0, 1'b0);
      end else begin
        j = loaded;
        loaded++;
        arr_tab[j] = arr;
        rem_tab[j] = ex;
        started_tab[j] = 0;
        slice_end_tab[j] = '0;
        pos = 0;
        while (pos < pend_q.size() && arr_tab[pend_q[pos]] <= arr) pos++;
        pend_q.insert(pos, j);
        add_beat(rrjs_pkg::KIND_LOAD, now, 5'(j + 1), 16'd0, ex, 1'b0);
      end
    end else begin
      // release arrived jobs into the ready queue
      while (pend_q.size() > 0 && {16'd0, arr_tab[pend_q[0]]} <= now) begin
        j = pend_q.pop_front();
        if (ready_q.size() < NJOBS) ready_q.push_back(j);
        add_beat(rrjs_pkg::KIND_RELEASE, now, 5'(j + 1), 16'd0, rem_tab[j], 1'b0);
      end
      if (ready_q.size() > 0) begin
        j = ready_q.pop_front();
        slot = (slot_len == 0) ? 16'd1 : slot_len;
        run = (rem_tab[j] < slot) ? rem_tab[j] : slot;
        t0 = now;
        if (!started_tab[j]) begin
          started_tab[j] = 1;
          wait_acc = sat32(wait_acc, t0 - {16'd0, arr_tab[j]});
        end else begin
          wait_acc = sat32(wait_acc, t0 - slice_end_tab[j]);
        end
        busy_acc = sat32(busy_acc, {16'd0, run});
        rem_tab[j] = rem_tab[j] - run;
        now = sat32(t0, {16'd0, run});
        if (rem_tab[j] != 0) begin
          slice_end_tab[j] = now;
          ready_q.push_back(j);
        end
        add_beat(rrjs_pkg::KIND_RAN, t0, 5'(j + 1), run, rem_tab[j], rem_tab[j] == 0);
      end else begin
        t0 = now;
        now = sat32(t0, 32'd1);
        add_beat(rrjs_pkg::KIND_IDLE, t0, 5'd0, 16'd1, 16'd0, 1'b0);
      end
    end
    pending_beats[$].last = 1'b1;
  endfunction

  function void report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40)
      $display("beat %0d: %s got %0h want %0h", beats_seen, what, got, want);
  endfunction

  // compare one accepted result beat with the oldest expectation
  function void check_result(sched_beat_t g);
    sched_beat_t e;
    beats_seen++;
    if (pending_beats.size() == 0) begin
      report("unexpected beat, kind", 32'(g.kind), 32'd0);
      return;
    end
    e = pending_beats.pop_front();
    if (g.kind !== e.kind) report("kind", 32'(g.kind), 32'(e.kind));
    if (g.event_time !== e.event_time) report("event_time", g.event_time, e.event_time);
    if (g.job_id !== e.job_id) report("job_id", 32'(g.job_id), 32'(e.job_id));
    if (g.run_length !== e.run_length) report("run_length", 32'(g.run_length),
                                              32'(e.run_length));
    if (g.remaining !== e.remaining) report("remaining", 32'(g.remaining), 32'(e.remaining));
    if (g.job_done !== e.job_done) report("job_done", 32'(g.job_done), 32'(e.job_done));
    if (g.wait_total !== e.wait_total) report("wait_total", g.wait_total, e.wait_total);
    if (g.busy_total !== e.busy_total) report("busy_total", g.busy_total, e.busy_total);
    if (g.all_finished !== e.all_finished) report("all_finished", 32'(g.all_finished),
                                                  32'(e.all_finished));
    if (g.last !== e.last) report("last", 32'(g.last), 32'(e.last));
  endfunction
endclass

module testbench;
  import rrjs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  rrjs_in_if  in_ch ();
  rrjs_out_if out_ch ();

  sched_scoreboard sb = new();

  int  src_idle_pct = 12;
  int  snk_idle_pct = 88;
  bit  hold_off = 1'b0;
  int  cycles = 0;
  int  loads_sent = 0;
  int  steps_sent = 0;

  round_robin_job_scheduler i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.job_arrival = '0;
    in_ch.job_exec_time = '0;
    out_ch.ready = 1'b0;
  end

  // timeout watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stall, sample at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni)
      out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    sched_beat_t g;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      g.kind = out_ch.kind;
      g.event_time = out_ch.event_time;
      g.job_id = out_ch.job_id;
      g.run_length = out_ch.run_length;
      g.remaining = out_ch.remaining;
      g.job_done = out_ch.job_done;
      g.wait_total = out_ch.wait_total;
      g.busy_total = out_ch.busy_total;
      g.all_finished = out_ch.all_finished;
      g.last = out_ch.last;
      sb.check_result(g);
    end
  end

  // offer one input beat and wait for it to be taken; valid stays up after
  // the beat until the next beat or an idle stretch takes it down
  task automatic send_item(logic fn, logic [15:0] arr, logic [15:0] ex);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.job_arrival <= arr;
    in_ch.job_exec_time <= ex;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(fn, arr, ex);
    if (fn == FUNC_LOAD) loads_sent++;
    else steps_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_beats.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // apb write of slot_length, block must be idle
  task automatic write_slot(logic [15:0] val);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 3'(REG_SLOT_LENGTH * 4);
    pwdata <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.slot_len = val;
  endtask

  // a batch of loads followed by nsteps steps, about one in ten of them a load instead
  task automatic run_batch(int njobs, int max_arr, int max_ex, int nsteps);
    for (int k = 0; k < njobs; k++)
      send_item(FUNC_LOAD, 16'($urandom_range(max_arr)), 16'($urandom_range(max_ex)));
    for (int k = 0; k < nsteps; k++) begin
      if ($urandom_range(9) == 0)
        send_item(FUNC_LOAD, 16'($urandom), 16'($urandom_range(1)));
      else
        send_item(FUNC_STEP, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: ignored load, equal arrivals, extremes, idle tick
    send_item(FUNC_LOAD, 16'd5, 16'd0);
    send_item(FUNC_STEP, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_LOAD, 16'd3, 16'd2);
    send_item(FUNC_LOAD, 16'd0, 16'd3);
    send_item(FUNC_LOAD, 16'd3, 16'd1);
    send_item(FUNC_LOAD, 16'd0, 16'hFFFF);
    for (int k = 0; k < 8; k++) send_item(FUNC_STEP, 16'd0, 16'd0);
    write_slot(16'd0);
    for (int k = 0; k < 3; k++) send_item(FUNC_STEP, 16'd0, 16'd0);
    write_slot(16'hFFFF);
    send_item(FUNC_STEP, 16'd0, 16'd0);
    // fill the job table, then a load beyond it is ignored
    for (int k = 0; k < 12; k++) send_item(FUNC_LOAD, 16'hFFFF, 16'($urandom_range(1, 9)));
    send_item(FUNC_LOAD, 16'd1, 16'd7);
    send_item(FUNC_STEP, 16'd0, 16'd0);

    // random phase, sender mostly busy, receiver mostly stalling
    write_slot(16'd3);
    run_batch(10, 20, 12, 25);

    // long hold-off on the receiver while steps keep coming
    src_idle_pct = 88;
    snk_idle_pct = 12;
    write_slot(16'd1);
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      run_batch(0, 0, 0, 20);
    join

    write_slot(16'd7);
    run_batch(6, 400, 30, 30);

    // no idling, big job loads (ignored, the job table is full) and a long slot
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_slot(16'hFFFF);
    run_batch(4, 65535, 65535, 30);
    write_slot(16'd2);
    run_batch(0, 0, 0, 30);

    wait_drained();
    $display("sent %0d loads and %0d steps, checked %0d result beats",
             loads_sent, steps_sent, sb.beats_seen);
    $display("slot lengths 0, 1, 2, 3, 7 and 65535 used, with idle, release and full-table cases");
    if (sb.errors == 0 && sb.pending_beats.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule

// ----- round_robin_job_scheduler.f -----
hw/rtl/rrjs_pkg.sv
hw/rtl/rrjs_if.sv
hw/rtl/rrjs_pend_cell.sv
hw/rtl/rrjs_ready_cell.sv
hw/rtl/round_robin_job_scheduler.sv
tb/testbench.sv
